FILE: design/abo_pkg.sv
// ----------------------------------------------------------------------------
// ARGB over-blend package
// Shared payload types and constants for the source-over blend pipeline.
// ----------------------------------------------------------------------------
package abo_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned NumLanes    = 3;   // red, green, blue
  localparam int unsigned NumDivSteps = 8;   // one quotient bit per stage
  localparam int unsigned RemW        = 24;  // holds 255 * 65025
  localparam int unsigned DenW        = 16;  // holds 65025
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // one request: base pixel and overlay pixel
  typedef struct packed {
    logic [ChanW-1:0] base_alpha;
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_blue;
    logic [ChanW-1:0] overlay_alpha;
    logic [ChanW-1:0] overlay_red;
    logic [ChanW-1:0] overlay_green;
    logic [ChanW-1:0] overlay_blue;
  } in_t;

  // one result: blended pixel
  typedef struct packed {
    logic [ChanW-1:0] out_alpha;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } out_t;

  // state carried down the divider stages
  typedef struct packed {
    logic [NumLanes-1:0][RemW-1:0]  rem;
    logic [DenW-1:0]                den;
    logic [NumLanes-1:0][ChanW-1:0] quo;
    logic                           den_zero;
    logic                           bypass;
    out_t                           ovl;
  } div_t;

endpackage

FILE: design/argb_over_blend_top.sv
// ----------------------------------------------------------------------------
// ARGB over-blend top level
// Source-over composite of an overlay ARGB8888 pixel onto a base pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_data_i carry one request, a
//   base pixel and an overlay pixel. It is taken on a clock edge with
//   in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i / out_data_o carry the blended
//   pixel, in request order.
//   Pipeline: eleven register stages (two operand stages, eight divider
//   stages, one output register); the accepting edge loads the first, and
//   out_valid_o rises once the request reaches the output register.
//   Throughput: one request per cycle while in_stall_o is low. Every stage
//   holds its own valid bit, so bubbles collapse and a new request enters
//   while older ones are still in the divider.
//   Stall: out_stall_i freezes only the stages that are full up to the
//   output; in_stall_o rises only when every stage holds a request.
//   Reset: rst_ni clears all valid bits at once; the pipeline comes up empty
//   and ready. Only the valid bits are reset; the data registers are not.
//   Color quotients are resolved one bit per divider stage, restoring style;
//   alpha is D/255 by a reciprocal add-and-shift in the output stage.
// ----------------------------------------------------------------------------
module argb_over_blend_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  abo_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output abo_pkg::out_t out_data_o
);
  import abo_pkg::*;

  localparam int unsigned NumStages = NumDivSteps + 3;
  localparam int unsigned LastStage = NumStages - 1;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages:0]   en;
  div_t                 div_chain [NumDivSteps+1];
  out_t                 out_d, out_q;
  logic [DenW:0]        alpha_sum;

  // a stage loads when it is empty or its successor loads too
  assign en[NumStages] = !out_stall_i;
  for (genvar s = 0; s < NumStages; s++) begin : g_en
    assign en[s] = !valid_q[s] || en[s+1];
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int s = 1; s < NumStages; s++) begin
      if (en[s]) begin
        valid_d[s] = valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // operand stages: products, then numerators and denominator
  abo_prep u_prep (
    .clk_i     (clk_i),
    .en_a_i    (en[0]),
    .en_b_i    (en[1]),
    .in_data_i (in_data_i),
    .div_o     (div_chain[0])
  );

  // divider: MSB of the quotient first
  for (genvar k = 0; k < NumDivSteps; k++) begin : g_div
    abo_div_step #(
      .Bit (NumDivSteps - 1 - k)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en[k+2]),
      .div_i (div_chain[k]),
      .div_o (div_chain[k+1])
    );
  end

  // output select: pass-through for an empty base, zero color when D is zero
  always_comb begin
    // floor(D/255) = (D + (D >> 8) + 1) >> 8, exact for D up to 65025
    alpha_sum = {1'b0, div_chain[NumDivSteps].den}
              + (DenW+1)'(div_chain[NumDivSteps].den[DenW-1:8])
              + (DenW+1)'(1);
    if (div_chain[NumDivSteps].bypass) begin
      out_d = div_chain[NumDivSteps].ovl;
    end else begin
      out_d.out_alpha = alpha_sum[ChanW +: ChanW];
      if (div_chain[NumDivSteps].den_zero) begin
        out_d.out_red   = '0;
        out_d.out_green = '0;
        out_d.out_blue  = '0;
      end else begin
        out_d.out_red   = div_chain[NumDivSteps].quo[0];
        out_d.out_green = div_chain[NumDivSteps].quo[1];
        out_d.out_blue  = div_chain[NumDivSteps].quo[2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LastStage]) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[LastStage];
  assign out_data_o  = out_q;

endmodule

FILE: design/abo_prep.sv
// ----------------------------------------------------------------------------
// ARGB over-blend operand preparation
// Two register stages: partial products, then numerators and the denominator.
// ----------------------------------------------------------------------------
module abo_prep (
  input  logic          clk_i,
  input  logic          en_a_i,
  input  logic          en_b_i,
  input  abo_pkg::in_t  in_data_i,
  output abo_pkg::div_t div_o
);
  import abo_pkg::*;

  typedef struct packed {
    logic [2:0][15:0] bab;    // base channel * base alpha
    logic [2:0][15:0] oao;    // overlay channel * overlay alpha
    logic [15:0]      abao;   // base alpha * overlay alpha
    logic [8:0]       asum;
    logic [7:0]       nao;    // 255 - overlay alpha
    logic             bypass;
    out_t             ovl;
  } prod_t;

  prod_t prod_d, prod_q;
  div_t  div_d, div_q;
  logic [16:0] den_wide;

  always_comb begin
    prod_d.bab[0] = 16'(in_data_i.base_red)   * 16'(in_data_i.base_alpha);
    prod_d.bab[1] = 16'(in_data_i.base_green) * 16'(in_data_i.base_alpha);
    prod_d.bab[2] = 16'(in_data_i.base_blue)  * 16'(in_data_i.base_alpha);
    prod_d.oao[0] = 16'(in_data_i.overlay_red)   * 16'(in_data_i.overlay_alpha);
    prod_d.oao[1] = 16'(in_data_i.overlay_green) * 16'(in_data_i.overlay_alpha);
    prod_d.oao[2] = 16'(in_data_i.overlay_blue)  * 16'(in_data_i.overlay_alpha);
    prod_d.abao   = 16'(in_data_i.base_alpha) * 16'(in_data_i.overlay_alpha);
    prod_d.asum   = 9'(in_data_i.base_alpha) + 9'(in_data_i.overlay_alpha);
    prod_d.nao    = ChanMax - in_data_i.overlay_alpha;
    // all-zero base word lets the overlay through untouched
    prod_d.bypass = ({in_data_i.base_alpha, in_data_i.base_red,
                      in_data_i.base_green, in_data_i.base_blue} == '0);
    prod_d.ovl.out_alpha = in_data_i.overlay_alpha;
    prod_d.ovl.out_red   = in_data_i.overlay_red;
    prod_d.ovl.out_green = in_data_i.overlay_green;
    prod_d.ovl.out_blue  = in_data_i.overlay_blue;
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      prod_q <= prod_d;
    end
  end

  // D = 255*(ab+ao) - ab*ao; an opaque base reduces to the same rational
  always_comb begin
    den_wide = {prod_q.asum, 8'b0} - 17'(prod_q.asum) - 17'(prod_q.abao);
    div_d.den      = den_wide[DenW-1:0];
    div_d.den_zero = (den_wide == '0);
    for (int l = 0; l < NumLanes; l++) begin
      div_d.rem[l] = RemW'(prod_q.bab[l]) * RemW'(prod_q.nao)
                   + ({prod_q.oao[l], 8'b0} - RemW'(prod_q.oao[l]));
    end
    div_d.quo    = '0;
    div_d.bypass = prod_q.bypass;
    div_d.ovl    = prod_q.ovl;
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

FILE: design/abo_div_step.sv
// ----------------------------------------------------------------------------
// ARGB over-blend divider step
// One registered restoring-division step: resolves quotient bit Bit per lane.
// ----------------------------------------------------------------------------
module abo_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  abo_pkg::div_t div_i,
  output abo_pkg::div_t div_o
);
  import abo_pkg::*;

  div_t div_d, div_q;
  logic [RemW-1:0] shifted;

  always_comb begin
    div_d   = div_i;
    // color lanes all divide by D
    shifted = RemW'(div_i.den) << Bit;
    for (int l = 0; l < NumLanes; l++) begin
      if (div_i.rem[l] >= shifted) begin
        div_d.rem[l]      = div_i.rem[l] - shifted;
        div_d.quo[l][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

FILE: design/abo_checker.sv
// ----------------------------------------------------------------------------
// ARGB over-blend port checker
// Port-level assertions for the blend pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module abo_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input abo_pkg::out_t out_data_o
);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // the input backs up only when a result is presented and blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

endmodule

bind argb_over_blend_top abo_checker u_abo_checker (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// ARGB over-blend testbench
// Drives base/overlay pixel pairs through argb_over_blend_top under random
// sender gaps and receiver stalls, predicts each blended pixel with exact
// integer source-over math, and checks results in order, lane by lane.
// ----------------------------------------------------------------------------
module testbench;
  import abo_pkg::*;

  localparam int unsigned Full      = 255;
  localparam int unsigned MaxGap    = 13;
  localparam int unsigned HoldLen   = 400;    // long receiver hold-off, cycles
  localparam int unsigned Tail      = 24;     // settle time after the last pixel
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseLen  = 103;

  // --------------------------------------------------------------------------
  // Expected-pixel store plus predictor
  // --------------------------------------------------------------------------
  class blend_scoreboard;
    out_t        pixel_q[$];
    int unsigned errors;

    // Exact source-over. An opaque base falls out of the general rule:
    // D = 65025 there, and the 255 factor cancels from the channel quotient.
    static function out_t blend_pixel(in_t px);
      int unsigned     ab, ao, den;
      logic [3:0][7:0] b, o, r;
      b  = {px.base_alpha, px.base_red, px.base_green, px.base_blue};
      o  = {px.overlay_alpha, px.overlay_red, px.overlay_green, px.overlay_blue};
      ab = px.base_alpha;
      ao = px.overlay_alpha;
      if (b == '0) begin
        // empty base: overlay passes through untouched
        r = o;
      end else begin
        den  = Full * (ab + ao) - ab * ao;
        r[3] = 8'(den / Full);
        for (int i = 0; i < 3; i++) begin
          r[i] = (den == 0) ? 8'd0
                            : 8'((b[i] * ab * (Full - ao) + Full * o[i] * ao) / den);
        end
      end
      return out_t'(r);
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction

    function void note_request(in_t px);
      pixel_q.push_back(blend_pixel(px));
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task check_pixel(out_t got);
      string           lane_name[4];
      logic [3:0][7:0] g, w;
      lane_name = '{"blue", "green", "red", "alpha"};
      if (pixel_q.size() == 0) begin
        report("unexpected pixel", got, 0);
      end else begin
        g = got;
        w = pixel_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (g[i] !== w[i]) report(lane_name[i], g[i], w[i]);
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  argb_over_blend_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  blend_scoreboard sb = new;

  // idle knobs, flipped per phase by the main sequence
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;

  // --------------------------------------------------------------------------
  // Monitor: samples pre-edge values, so handshakes are read race-free.
  // Output is checked before the input is noted; latency keeps them apart.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_pixel(out_data);
      if (in_valid && !in_stall)   sb.note_request(in_data);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall before each pixel, plus an occasional long hold
  // requested by the main sequence and counted here.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      // out_stall is low at every edge in this wait, so valid means taken
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Sender. valid stays high across back-to-back requests; a gap drops it.
  // --------------------------------------------------------------------------
  task automatic send_request(in_t px);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_t pixel_pair(byte unsigned ab, byte unsigned br, byte unsigned bg,
                                     byte unsigned bb, byte unsigned ao, byte unsigned orr,
                                     byte unsigned og, byte unsigned ob);
    return '{base_alpha: ab, base_red: br, base_green: bg, base_blue: bb,
             overlay_alpha: ao, overlay_red: orr, overlay_green: og, overlay_blue: ob};
  endfunction

  // Random request, biased toward the interesting cases of the blend.
  function automatic in_t random_request();
    in_t         px;
    int unsigned pick;
    px   = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // empty base: pass-through
      {px.base_alpha, px.base_red, px.base_green, px.base_blue} = '0;
    end else if (pick < 30) begin
      px.base_alpha = ChanMax;
    end else if (pick < 38) begin
      // both alphas zero with some base color: all-zero result
      px.base_alpha    = '0;
      px.overlay_alpha = '0;
      if (px.base_red == 0) px.base_red = 8'd1;
    end else if (pick < 46) begin
      px.overlay_alpha = ($urandom_range(0, 1) != 0) ? ChanMax : 8'd0;
    end else if (pick < 58) begin
      // field extremes everywhere
      px = '0;
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 3))
          0: px[i*8 +: 8] = 8'd0;
          1: px[i*8 +: 8] = 8'd1;
          2: px[i*8 +: 8] = 8'd254;
          default: px[i*8 +: 8] = 8'd255;
        endcase
      end
    end
    return px;
  endfunction

  // the first edge lets the monitor note the request taken at the current one
  task automatic drain();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_t directed_q[$];
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    rst_ni         = 1'b0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: pass-through, opaque base, both alphas zero, extremes
    directed_q = '{
      pixel_pair(  0,   0,   0,   0,   0,   0,   0,   0),
      pixel_pair(  0,   0,   0,   0, 255, 255, 255, 255),
      pixel_pair(  0,   0,   0,   0, 128,  17, 200,  99),
      pixel_pair(255,  10, 200,  30,   0, 255, 255, 255),
      pixel_pair(255,  10, 200,  30, 255,   1,   2,   3),
      pixel_pair(255, 255,   0, 128, 128,   0, 255,  77),
      pixel_pair(255, 255, 255, 255, 255, 255, 255, 255),
      pixel_pair(255,   0,   0,   0,   1, 255, 255, 255),
      pixel_pair(  0,  50,  60,  70,   0, 255, 255, 255),
      pixel_pair(  0, 255, 255, 255,   0,   0,   0,   0),
      pixel_pair(  0,   0,   0,   1,   0,  80,  90, 100),
      pixel_pair(  0, 255, 255, 255, 255,   0,   0,   0),
      pixel_pair(  0, 100, 100, 100,   1, 200, 200, 200),
      pixel_pair(  1, 255, 255, 255,   0,   0,   0,   0),
      pixel_pair(  1,   0,   0,   0,   1, 255, 255, 255),
      pixel_pair(254, 255, 255, 255, 254,   0,   0,   0),
      pixel_pair(254,   0, 255,   0, 255, 255,   0, 255),
      pixel_pair(254, 255,   0, 255,   1,   0, 255,   0),
      pixel_pair(128, 128, 128, 128, 128, 128, 128, 128),
      pixel_pair( 77, 255,   1, 254,  33,   0, 254,   1)
    };
    foreach (directed_q[i]) send_request(directed_q[i]);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (p == 4) begin
        // long receiver hold while requests keep coming: pipeline fills and
        // in_stall must rise
        tx_idle_en     = 1'b0;
        rx_hold_cycles = HoldLen;
      end
      for (int k = 0; k < PhaseLen; k++) send_request(random_request());
      // sender pauses for a full drain twice
      if (p == 2 || p == 6) begin
        in_valid <= 1'b0;
        drain();
      end
    end
    in_valid <= 1'b0;

    drain();
    repeat (Tail) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit: far above the slowest legal run (every pixel eating a full
  // sender gap and a full receiver stall, plus the long hold).
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
